// ----- sv/msq_pkg.sv -----
// Package for the musical scale quantizer: configuration types, constants and scale masks.
package msq_pkg;

  localparam int unsigned NoteW     = 7;
  localparam int unsigned ClassW    = 4;
  localparam int unsigned OctaveW   = 4;
  localparam int unsigned ScaleW    = 4;
  localparam int unsigned NumScales = 16;
  localparam int unsigned PaddrW    = 4;
  localparam int unsigned DataW     = 32;
  localparam int unsigned SearchSpan = 6;

  localparam logic [ClassW-1:0] PitchClasses = 4'd12;
  localparam logic [NoteW:0]    NoteMax      = 8'd127;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] RegEnable = 2'd0;
  localparam logic [1:0] RegRoot   = 2'd1;
  localparam logic [1:0] RegScale  = 2'd2;

  typedef struct packed {
    logic              enable;
    logic [ClassW-1:0] root;
    logic [ScaleW-1:0] scale;
  } cfg_t;

  // Bit i set means the degree i semitones above the root is in the scale.
  localparam logic [11:0] ScaleMasks [NumScales] = '{
    12'hFFF, 12'hAB5, 12'h5AD, 12'h9AD, 12'hAAD, 12'h6AD, 12'h5AB, 12'hAD5,
    12'h6B5, 12'h56B, 12'h295, 12'h4A9, 12'h4E9, 12'h555, 12'hB6D, 12'h999
  };

endpackage

// ----- sv/msq_regs.sv -----
// APB-style configuration registers of the musical scale quantizer.
module msq_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msq_pkg::PaddrW-1:0]  paddr,
  input  logic [msq_pkg::DataW-1:0]   pwdata,
  output logic [msq_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output msq_pkg::cfg_t               cfg_o
);

  msq_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [msq_pkg::ClassW-1:0] root_wr;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // The root is reduced modulo 12 as it is written.
  assign root_wr = (pwdata[3:0] >= msq_pkg::PitchClasses) ?
                   (pwdata[3:0] - msq_pkg::PitchClasses) : pwdata[3:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        msq_pkg::RegEnable: cfg_d.enable = pwdata[0];
        msq_pkg::RegRoot:   cfg_d.root   = root_wr;
        msq_pkg::RegScale:  cfg_d.scale  = pwdata[3:0];
        default:            cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[3:2])
      msq_pkg::RegEnable: prdata = {31'd0, cfg_q.enable};
      msq_pkg::RegRoot:   prdata = {28'd0, cfg_q.root};
      msq_pkg::RegScale:  prdata = {28'd0, cfg_q.scale};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/msq_quant.sv -----
// Combinational snap of one note to the nearest degree of the selected scale.
module msq_quant (
  input  logic [msq_pkg::NoteW-1:0] note_i,
  input  msq_pkg::cfg_t             cfg_i,
  output logic [msq_pkg::NoteW-1:0] note_o
);

  logic [11:0]                  mask;
  logic [msq_pkg::NoteW+5:0]    recip;
  logic [msq_pkg::OctaveW-1:0]  octave;
  logic [msq_pkg::ClassW-1:0]   semi;
  logic [msq_pkg::ClassW-1:0]   rel;
  logic [msq_pkg::ClassW-1:0]   best_rel;
  logic [msq_pkg::ClassW:0]     cls_sum;
  logic [msq_pkg::ClassW-1:0]   cls;
  logic [msq_pkg::NoteW:0]      placed;

  assign mask = msq_pkg::ScaleMasks[cfg_i.scale];

  // note / 12 as (note * 43) >> 9, exact for every 7-bit note.
  assign recip  = {6'd0, note_i} * 13'd43;
  assign octave = recip[12:9];
  assign semi   = msq_pkg::ClassW'(note_i - (msq_pkg::NoteW'(octave) * 7'd12));

  assign rel = (semi >= cfg_i.root) ? (semi - cfg_i.root)
                                    : (semi + msq_pkg::PitchClasses - cfg_i.root);

  // Nearest degree: at each distance the upward candidate is tried first.
  always_comb begin
    logic                        found;
    logic [msq_pkg::ClassW:0]    up_sum;
    logic [msq_pkg::ClassW-1:0]  up;
    logic [msq_pkg::ClassW-1:0]  down;
    logic [msq_pkg::ClassW-1:0]  delta;
    found    = 1'b0;
    best_rel = rel;
    for (int d = 0; d <= int'(msq_pkg::SearchSpan); d++) begin
      delta  = msq_pkg::ClassW'(d);
      up_sum = {1'b0, rel} + {1'b0, delta};
      up     = (up_sum >= {1'b0, msq_pkg::PitchClasses}) ?
               msq_pkg::ClassW'(up_sum - {1'b0, msq_pkg::PitchClasses}) :
               up_sum[msq_pkg::ClassW-1:0];
      down   = (rel >= delta) ? (rel - delta) : (rel + msq_pkg::PitchClasses - delta);
      if (!found) begin
        if (mask[up]) begin
          best_rel = up;
          found    = 1'b1;
        end else if (mask[down]) begin
          best_rel = down;
          found    = 1'b1;
        end
      end
    end
  end

  assign cls_sum = {1'b0, best_rel} + {1'b0, cfg_i.root};
  assign cls     = (cls_sum >= {1'b0, msq_pkg::PitchClasses}) ?
                   msq_pkg::ClassW'(cls_sum - {1'b0, msq_pkg::PitchClasses}) :
                   cls_sum[msq_pkg::ClassW-1:0];

  assign placed = ({4'd0, octave} * 8'd12) + {4'd0, cls};

  always_comb begin
    if (!cfg_i.enable) begin
      note_o = note_i;
    end else if (placed > msq_pkg::NoteMax) begin
      note_o = msq_pkg::NoteMax[msq_pkg::NoteW-1:0];
    end else begin
      note_o = placed[msq_pkg::NoteW-1:0];
    end
  end

endmodule

// ----- sv/musical_scale_quantizer.sv -----
// Top level of the musical scale quantizer: input register, quantizer and result register.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         in_valid_i / in_stall_o    note_in_i  (7 bits)
//   output    out        out_valid_o / out_stall_i  note_out_o (7 bits)
//   config    in         psel / penable / pready    paddr, pwdata, prdata
//
// A note's result passes through the input register and then the result
// register, with the whole scale search done in the logic between them. A new
// note can be taken in every cycle in which in_stall_o is low.
// Reset clears the valid flags and the configuration (quantizing off, root 0,
// chromatic scale). While the result waits under out_stall_i, the input register
// still takes one more note; only when both stages are full does in_stall_o rise.
module musical_scale_quantizer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msq_pkg::PaddrW-1:0]  paddr,
  input  logic [msq_pkg::DataW-1:0]   pwdata,
  output logic [msq_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [msq_pkg::NoteW-1:0]   note_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [msq_pkg::NoteW-1:0]   note_out_o
);

  msq_pkg::cfg_t               cfg;
  logic                        s1_valid_q, s1_valid_d;
  logic [msq_pkg::NoteW-1:0]   s1_note_q, s1_note_d;
  logic                        out_valid_q, out_valid_d;
  logic [msq_pkg::NoteW-1:0]   out_note_q, out_note_d;
  logic [msq_pkg::NoteW-1:0]   quant_note;
  logic                        out_hold;
  logic                        s1_move;
  logic                        in_take;

  msq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  msq_quant u_quant (
    .note_i (s1_note_q),
    .cfg_i  (cfg),
    .note_o (quant_note)
  );

  // The result register holds while its transfer is stalled; otherwise the
  // note in the input register moves on and a fresh note may take its place.
  assign out_hold   = out_valid_q && out_stall_i;
  assign s1_move    = s1_valid_q && !out_hold;
  assign in_stall_o = s1_valid_q && out_hold;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_note_d   = s1_note_q;
    out_valid_d = out_valid_q;
    out_note_d  = out_note_q;
    if (!out_hold) begin
      out_valid_d = s1_valid_q;
      if (s1_valid_q) begin
        out_note_d = quant_note;
      end
    end
    if (in_take) begin
      s1_valid_d = 1'b1;
      s1_note_d  = note_in_i;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_note_q  <= s1_note_d;
    out_note_q <= out_note_d;
  end

  assign out_valid_o = out_valid_q;
  assign note_out_o  = out_note_q;

`ifndef SYNTH
  // A note leaving the input register always lands in the result register.
  a_move_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("note lost between input and result register");

  // A blocked note in the input register is kept, not overwritten.
  a_s1_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_hold) |=> (s1_valid_q && $stable(s1_note_q)))
    else $error("blocked note in input register was lost");

  // With quantizing off the note passes through unchanged.
  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && !cfg.enable) |=> (out_note_q == $past(s1_note_q)))
    else $error("bypassed note was altered");
`endif

endmodule
